@@ hdl/eml_pkg.sv @@
// ----------------------------------------------------------------------------
// eml_pkg
// Shared types and constants for the extent map lookup block.
// ----------------------------------------------------------------------------
package eml_pkg;

  localparam int MAX_EXTENTS = 64;
  localparam int AW          = 48;
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_HIT      = 3'd2,
    ST_MISS     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_t;

  // query token walking down the cell chain
  typedef struct packed {
    logic          valid;
    logic          done;
    logic          hit;
    logic [AW-1:0] off;
    logic [AW-1:0] len;
    logic [AW:0]   qend;
    logic [AW:0]   ext_end;
    logic [AW-1:0] delta;
  } tok_t;

  // extent write data, broadcast to all cells
  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW:0]   ext_end;
    logic [AW-1:0] delta;
  } ext_t;

  typedef struct packed {
    logic wr_en;
    logic ent_valid;
  } cell_ctl_t;

  typedef struct packed {
    status_t       status;
    logic [AW-1:0] hit_length;
    logic [AW-1:0] source_address;
  } res_t;

endpackage

@@ hdl/extent_map_lookup_core.sv @@
// ----------------------------------------------------------------------------
// extent_map_lookup_core
// Extent table with append, clear and range lookup over a chain of cells.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in_ stream, cmd in in_tuser, the offset,
// length and source offset in in_tdata. Each transaction gives exactly one
// result transaction on the out_ stream, status in out_tuser.
// Clear and append answer from the output register: the result is registered
// on the edge that takes the command and shows the cycle after.
// A lookup sends a token down a chain of MAX_EXTENTS cells, one cell per
// cycle, then through one finishing register into the output register; the
// token walks the whole chain whatever the table holds. One lookup is in
// flight at a time, so no new command is taken until its result is loaded;
// a clear or append can be taken every clock while the output is not stalled.
// in_tready drops during a lookup walk and drain and while the output register
// holds a result that the receiver stalls on and no room is free for a new one.
// A stalled result is held unchanged until out_tready.
// Reset empties the table (count to zero) and drops all tokens and output
// valid; stored extents need no clearing since only counted ones are read.
// ----------------------------------------------------------------------------
module extent_map_lookup_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [143:0]  in_tdata,   // dest_offset, length, src_offset
  input  logic [1:0]    in_tuser,   // cmd
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [95:0]   out_tdata,  // hit_length, source_address
  output logic [2:0]    out_tuser   // status
);
  import eml_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  res_t             out_res_r;
  res_t             out_res_nxt;

  logic [AW-1:0]    in_doff;
  logic [AW-1:0]    in_len;
  logic [AW-1:0]    in_soff;
  cmd_t             in_cmd;
  logic             in_acc;
  logic             append_acc;
  logic             out_free;
  logic             load_in;
  logic             load_fin;
  ext_t             wr;
  res_t             fin_res;
  tok_t             chain [MAX_EXTENTS+1];
  cell_ctl_t        ctl [MAX_EXTENTS];

  assign in_doff = in_tdata[AW-1:0];
  assign in_len  = in_tdata[2*AW-1:AW];
  assign in_soff = in_tdata[3*AW-1:2*AW];
  assign in_cmd  = cmd_t'(in_tuser);

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign append_acc = in_acc && (in_cmd == CMD_APPEND) && (count_r != CNT_W'(MAX_EXTENTS));
  assign load_in    = in_acc && (in_cmd != CMD_LOOKUP);
  assign load_fin   = (state_r == S_DRAIN) && out_free;

  assign wr.start   = in_doff;
  assign wr.ext_end = {1'b0, in_doff} + {1'b0, in_len};
  assign wr.delta   = in_soff - in_doff;

  always_comb begin
    chain[0]         = '0;
    chain[0].valid   = in_acc && (in_cmd == CMD_LOOKUP);
    chain[0].off     = in_doff;
    chain[0].len     = in_len;
    chain[0].qend    = {1'b0, in_doff} + {1'b0, in_len};
  end

  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    assign ctl[i].wr_en     = append_acc && (count_r == CNT_W'(i));
    assign ctl[i].ent_valid = CNT_W'(i) < count_r;

    eml_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[i]),
      .wr      (wr),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  eml_finish u_finish (
    .clk (clk),
    .tok (chain[MAX_EXTENTS]),
    .res (fin_res)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_CLEAR: begin
              count_nxt   = '0;
              out_res_nxt = '{status: ST_CLEARED, hit_length: '0, source_address: '0};
            end
            CMD_APPEND: begin
              if (count_r == CNT_W'(MAX_EXTENTS)) begin
                out_res_nxt = '{status: ST_FULL, hit_length: '0, source_address: '0};
              end else begin
                count_nxt   = count_r + CNT_W'(1);
                out_res_nxt = '{status: ST_APPENDED, hit_length: '0, source_address: '0};
              end
            end
            CMD_LOOKUP: begin
              state_nxt = S_WALK;
            end
            default: begin
              out_res_nxt = '{status: ST_MISS, hit_length: '0, source_address: '0};
            end
          endcase
          if (load_in) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (chain[MAX_EXTENTS].valid) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (load_fin) begin
          out_res_nxt   = fin_res;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {out_res_r.source_address, out_res_r.hit_length};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_EXTENTS))
    else $error("extent count above table depth");

  a_lookup_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_cmd == CMD_LOOKUP)) |=> (state_r == S_WALK))
    else $error("lookup accepted without starting a walk");

  a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    chain[MAX_EXTENTS].valid |-> (state_r == S_WALK))
    else $error("token left the chain outside a walk");

  a_drain_held: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DRAIN) && out_valid_r && !out_tready) |=> (state_r == S_DRAIN))
    else $error("lookup result dropped while output stalled");

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({load_in, load_fin}))
    else $error("two sources loading the output register");
`endif

endmodule

@@ hdl/eml_cell.sv @@
// ----------------------------------------------------------------------------
// eml_cell
// One table entry; checks the passing query token against its extent.
// ----------------------------------------------------------------------------
module eml_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  eml_pkg::cell_ctl_t ctl,
  input  eml_pkg::ext_t     wr,
  input  eml_pkg::tok_t     tok_in,
  output eml_pkg::tok_t     tok_out
);
  import eml_pkg::*;

  ext_t ext_r;
  tok_t tok_r;
  tok_t tok_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ext_r <= wr;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.done && ctl.ent_valid) begin
      priority if (ext_r.ext_end <= {1'b0, tok_in.off}) begin
        // extent lies wholly below the query, keep walking
        tok_nxt.done = 1'b0;
      end else if (tok_in.qend <= {1'b0, ext_r.start}) begin
        tok_nxt.done = 1'b1;
        tok_nxt.hit  = 1'b0;
      end else if (ext_r.start <= tok_in.off) begin
        tok_nxt.done    = 1'b1;
        tok_nxt.hit     = 1'b1;
        tok_nxt.ext_end = ext_r.ext_end;
        tok_nxt.delta   = ext_r.delta;
      end else begin
        // extent starts inside the query past its offset, passed over
        tok_nxt.done = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

@@ hdl/eml_finish.sv @@
// ----------------------------------------------------------------------------
// eml_finish
// Turns the token leaving the chain into a registered lookup result.
// ----------------------------------------------------------------------------
module eml_finish (
  input  logic          clk,
  input  eml_pkg::tok_t tok,
  output eml_pkg::res_t res
);
  import eml_pkg::*;

  res_t          res_r;
  res_t          res_nxt;
  logic [AW:0]   avail;

  always_comb begin
    avail   = tok.ext_end - {1'b0, tok.off};
    res_nxt = '{status: ST_MISS, hit_length: '0, source_address: '0};
    if (tok.done && tok.hit) begin
      res_nxt.status = ST_HIT;
      // len < end - off is the same as qend < end
      res_nxt.hit_length     = (tok.qend < tok.ext_end) ? tok.len : avail[AW-1:0];
      res_nxt.source_address = tok.off + tok.delta;
    end
  end

  always_ff @(posedge clk) begin
    if (tok.valid) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
